// ===== src/mrkc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrkc_pkg: shared types and constants of the mixed radix key codec
// Item layouts, the per-item work record carried down the pipeline,
// register indexes and arithmetic widths.
// ----------------------------------------------------------------------------
package mrkc_pkg;

   localparam int RADIX_BITS      = 8;
   localparam int AXIS_SLOTS      = 6;
   localparam int KEY_BITS        = 32;
   localparam int AXIS_COUNT_BITS = 3;

   // decode splits a key over sub-stages, DIGIT_STEPS quotient bits each
   localparam int DIGIT_STEPS = 8;
   localparam int SUB_STAGES  = KEY_BITS / DIGIT_STEPS;

   // what each sub-stage of an axis slice does besides the divide steps
   localparam int SUB_CHECK  = 0;   // range check, index * stride
   localparam int SUB_ACCUM  = 1;   // key accumulate, overflow check
   localparam int SUB_STRIDE = 2;   // stride * radix, capped
   localparam int SUB_COUNT  = 3;   // variant count * radix, saturated

   localparam int STRIDE_BITS = KEY_BITS + 2;
   localparam int PROD_BITS   = STRIDE_BITS + RADIX_BITS;
   localparam int SUM_BITS    = PROD_BITS + 1;
   localparam int CPROD_BITS  = KEY_BITS + RADIX_BITS;

   localparam logic [STRIDE_BITS-1:0] STRIDE_CAP = {2'b10, {KEY_BITS{1'b0}}};
   localparam logic [KEY_BITS-1:0]    KEY_ONES   = {KEY_BITS{1'b1}};

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX_A0   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX_A1   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX_A2   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX_A3   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX_A4   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX_A5   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUDGET     = 3'd7;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [KEY_BITS-1:0]   key;
      logic [RADIX_BITS-1:0] index_in_0;
      logic [RADIX_BITS-1:0] index_in_1;
      logic [RADIX_BITS-1:0] index_in_2;
      logic [RADIX_BITS-1:0] index_in_3;
      logic [RADIX_BITS-1:0] index_in_4;
      logic [RADIX_BITS-1:0] index_in_5;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   packed_key;
      logic [RADIX_BITS-1:0] index_out_0;
      logic [RADIX_BITS-1:0] index_out_1;
      logic [RADIX_BITS-1:0] index_out_2;
      logic [RADIX_BITS-1:0] index_out_3;
      logic [RADIX_BITS-1:0] index_out_4;
      logic [RADIX_BITS-1:0] index_out_5;
      logic                  encode_error;
      logic                  key_in_range;
      logic [KEY_BITS-1:0]   variant_count;
      logic                  within_budget;
   } rsp_type;

   // per-item record moving through the axis slices
   typedef struct packed {
      logic                                   command;
      logic [KEY_BITS-1:0]                    key;
      logic [AXIS_SLOTS-1:0][RADIX_BITS-1:0]  idx;
      logic [AXIS_SLOTS-1:0][RADIX_BITS-1:0]  digit;
      logic [KEY_BITS-1:0]                    rest;    // dividend, becomes quotient
      logic [RADIX_BITS-1:0]                  part;    // partial remainder
      logic [KEY_BITS-1:0]                    bits;    // encoded key so far
      logic                                   enc_err;
      logic [STRIDE_BITS-1:0]                 stride;
      logic [PROD_BITS-1:0]                   prod;
      logic [KEY_BITS-1:0]                    count;
   } work_type;

endpackage
`default_nettype wire

// ===== src/mrkc_axis_slice.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrkc_axis_slice: pipeline slice for one axis
// SUB_STAGES registered sub-stages. Each runs DIGIT_STEPS restoring divide
// steps of the decode, plus one encode or count step. Valid/stall in and out.
// ----------------------------------------------------------------------------
module mrkc_axis_slice
   import mrkc_pkg::*;
#(
   parameter int AXIS = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire work_type              in_data,
   output logic                       in_stall,
   output logic                       out_valid,
   output work_type                   out_data,
   input  wire logic                  out_stall,
   input  wire logic [RADIX_BITS-1:0] radix,
   input  wire logic                  active
);

   logic     valid_ff [SUB_STAGES];
   logic     valid_in [SUB_STAGES];
   work_type data_ff  [SUB_STAGES];
   work_type data_in  [SUB_STAGES];
   logic     adv      [SUB_STAGES+1];

   logic [RADIX_BITS-1:0] r_eff;

   // decode and count treat a zero radix as one
   assign r_eff = (radix == '0) ? RADIX_BITS'(1) : radix;

   function automatic logic [KEY_BITS+RADIX_BITS-1:0] div_steps(
      input logic [KEY_BITS-1:0]   num,
      input logic [RADIX_BITS-1:0] part,
      input logic [RADIX_BITS-1:0] dvs
   );
      logic [KEY_BITS-1:0]   q;
      logic [RADIX_BITS-1:0] p;
      logic [RADIX_BITS:0]   trial;
      q = num;
      p = part;
      for (int i = 0; i < DIGIT_STEPS; i++) begin
         trial = {p, q[KEY_BITS-1]};
         q     = {q[KEY_BITS-2:0], 1'b0};
         if (trial >= {1'b0, dvs}) begin
            trial = trial - {1'b0, dvs};
            q[0]  = 1'b1;
         end
         p = trial[RADIX_BITS-1:0];
      end
      return {p, q};
   endfunction

   assign adv[SUB_STAGES] = !out_stall;
   assign in_stall        = !adv[0];
   assign out_valid       = valid_ff[SUB_STAGES-1];
   assign out_data        = data_ff[SUB_STAGES-1];

   for (genvar k = 0; k < SUB_STAGES; k++) begin : g_sub
      work_type src;
      logic     src_valid;

      if (k == 0) begin : g_first
         assign src       = in_data;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = data_ff[k-1];
         assign src_valid = valid_ff[k-1];
      end

      assign adv[k] = !valid_ff[k] || adv[k+1];

      always_comb begin
         logic [KEY_BITS+RADIX_BITS-1:0] dq;
         logic [RADIX_BITS-1:0]          p0;
         logic [SUM_BITS-1:0]            sum;
         logic [PROD_BITS-1:0]           sp;
         logic [CPROD_BITS-1:0]          cp;
         data_in[k]  = src;
         valid_in[k] = src_valid;
         p0  = (k == 0) ? '0 : src.part;
         dq  = div_steps(src.rest, p0, r_eff);
         sum = SUM_BITS'(src.bits) + SUM_BITS'(src.prod);
         sp  = PROD_BITS'(src.stride) * PROD_BITS'(radix);
         cp  = CPROD_BITS'(src.count) * CPROD_BITS'(r_eff);
         if (active) begin
            data_in[k].rest = dq[KEY_BITS-1:0];
            data_in[k].part = dq[KEY_BITS+RADIX_BITS-1:KEY_BITS];
            if (k == SUB_STAGES - 1) begin
               data_in[k].digit[AXIS] = dq[KEY_BITS+RADIX_BITS-1:KEY_BITS];
            end
            case (k)
               SUB_CHECK: begin
                  if (radix == '0 || src.idx[AXIS] >= radix) begin
                     data_in[k].enc_err = 1'b1;
                  end
                  data_in[k].prod = PROD_BITS'(src.idx[AXIS]) * PROD_BITS'(src.stride);
               end
               SUB_ACCUM: begin
                  if (sum[SUM_BITS-1:KEY_BITS] != '0) begin
                     data_in[k].enc_err = 1'b1;
                  end
                  data_in[k].bits = sum[KEY_BITS-1:0];
               end
               SUB_STRIDE: begin
                  data_in[k].stride = (sp > PROD_BITS'(STRIDE_CAP)) ?
                                      STRIDE_CAP : sp[STRIDE_BITS-1:0];
               end
               SUB_COUNT: begin
                  data_in[k].count = (cp[CPROD_BITS-1:KEY_BITS] != '0) ?
                                     KEY_ONES : cp[KEY_BITS-1:0];
               end
               default: begin
                  data_in[k].prod = src.prod;
               end
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k] && src_valid) begin
            data_ff[k] <= data_in[k];
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/mixed_radix_key_codec_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mixed_radix_key_codec_unit: mixed radix key encode / decode
// Packs per-axis indices into a 32-bit key (axis 0 least significant) or
// splits a key into indices, and reports variant count and range checks.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_data/req_stall carry one item: command, key, six indices.
//   rsp_valid/rsp_data/rsp_stall return exactly one result item per item.
//   csr_wr_en/csr_index/csr_wdata write axis count, six radices and the
//   budget ceiling; write only while no item is in flight.
// Pipeline: entry register, min(MAX_AXES, 6) axis slices, output register.
//   One item per cycle is accepted unless rsp_stall backs the pipeline up.
//   Each axis owns a slice of four stages; every stage runs eight bits of
//   the restoring divide of that axis plus one step of the encode or count
//   path (a multiply, or the key add); the divide sets the depth.
// Reset clears all valid bits and loads axis count 0, all radices 1 and
//   budget ceiling all ones.
// When rsp_stall is high, the pipeline keeps moving until its empty slots
//   fill; only then does req_stall rise. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module mixed_radix_key_codec_unit
   import mrkc_pkg::*;
#(
   parameter int MAX_AXES = 6
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire req_type                   req_data,
   output logic                           req_stall,
   output logic                           rsp_valid,
   output rsp_type                        rsp_data,
   input  wire logic                      rsp_stall,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int AXES_BUILT = (MAX_AXES < AXIS_SLOTS) ? MAX_AXES : AXIS_SLOTS;

   // configuration registers
   logic [AXIS_COUNT_BITS-1:0] axis_count_ff, axis_count_in;
   logic [RADIX_BITS-1:0]      radix_ff [AXIS_SLOTS];
   logic [RADIX_BITS-1:0]      radix_in [AXIS_SLOTS];
   logic [KEY_BITS-1:0]        budget_ff, budget_in;

   always_comb begin
      axis_count_in = axis_count_ff;
      radix_in      = radix_ff;
      budget_in     = budget_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_AXIS_COUNT: axis_count_in = csr_wdata[AXIS_COUNT_BITS-1:0];
            CSR_RADIX_A0:   radix_in[0]   = csr_wdata[RADIX_BITS-1:0];
            CSR_RADIX_A1:   radix_in[1]   = csr_wdata[RADIX_BITS-1:0];
            CSR_RADIX_A2:   radix_in[2]   = csr_wdata[RADIX_BITS-1:0];
            CSR_RADIX_A3:   radix_in[3]   = csr_wdata[RADIX_BITS-1:0];
            CSR_RADIX_A4:   radix_in[4]   = csr_wdata[RADIX_BITS-1:0];
            CSR_RADIX_A5:   radix_in[5]   = csr_wdata[RADIX_BITS-1:0];
            CSR_BUDGET:     budget_in     = csr_wdata[KEY_BITS-1:0];
            default:        budget_in     = budget_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_count_ff <= '0;
         budget_ff     <= KEY_ONES;
         for (int i = 0; i < AXIS_SLOTS; i++) begin
            radix_ff[i] <= RADIX_BITS'(1);
         end
      end else begin
         axis_count_ff <= axis_count_in;
         budget_ff     <= budget_in;
         radix_ff      <= radix_in;
      end
   end

   // entry stage
   logic     entry_valid_ff, entry_valid_in;
   work_type entry_ff, entry_in;
   logic     entry_adv;

   logic     chain_valid [AXES_BUILT+1];
   work_type chain_data  [AXES_BUILT+1];
   logic     chain_stall [AXES_BUILT+1];

   assign entry_adv = !entry_valid_ff || !chain_stall[0];
   assign req_stall = !entry_adv;

   always_comb begin
      entry_valid_in   = req_valid;
      entry_in         = '0;
      entry_in.command = req_data.command;
      entry_in.key     = req_data.key;
      entry_in.idx[0]  = req_data.index_in_0;
      entry_in.idx[1]  = req_data.index_in_1;
      entry_in.idx[2]  = req_data.index_in_2;
      entry_in.idx[3]  = req_data.index_in_3;
      entry_in.idx[4]  = req_data.index_in_4;
      entry_in.idx[5]  = req_data.index_in_5;
      entry_in.rest    = req_data.key;
      entry_in.stride  = STRIDE_BITS'(1);
      entry_in.count   = KEY_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (entry_adv) begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_adv && req_valid) begin
         entry_ff <= entry_in;
      end
   end

   assign chain_valid[0] = entry_valid_ff;
   assign chain_data[0]  = entry_ff;

   for (genvar a = 0; a < AXES_BUILT; a++) begin : g_axis
      mrkc_axis_slice #(
         .AXIS (a)
      ) u_slice (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[a]),
         .in_data   (chain_data[a]),
         .in_stall  (chain_stall[a]),
         .out_valid (chain_valid[a+1]),
         .out_data  (chain_data[a+1]),
         .out_stall (chain_stall[a+1]),
         .radix     (radix_ff[a]),
         .active    (axis_count_ff > AXIS_COUNT_BITS'(a))
      );
   end

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;
   logic     out_adv;
   work_type last;

   assign last                    = chain_data[AXES_BUILT];
   assign out_adv                 = !rsp_valid_ff || !rsp_stall;
   assign chain_stall[AXES_BUILT] = !out_adv;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data                = rsp_ff;

   always_comb begin
      rsp_valid_in         = chain_valid[AXES_BUILT];
      rsp_in               = '0;
      rsp_in.variant_count = last.count;
      rsp_in.key_in_range  = last.key < last.count;
      rsp_in.within_budget = last.count <= budget_ff;
      if (last.command == CMD_ENCODE) begin
         rsp_in.encode_error = last.enc_err;
         rsp_in.packed_key   = last.enc_err ? KEY_ONES : last.bits;
      end else begin
         rsp_in.index_out_0 = last.digit[0];
         rsp_in.index_out_1 = last.digit[1];
         rsp_in.index_out_2 = last.digit[2];
         rsp_in.index_out_3 = last.digit[3];
         rsp_in.index_out_4 = last.digit[4];
         rsp_in.index_out_5 = last.digit[5];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && chain_valid[AXES_BUILT]) begin
         rsp_ff <= rsp_in;
      end
   end

   // checks
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> entry_valid_ff)
      else $error("accepted item did not reach the entry stage");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.variant_count != '0)
      else $error("variant count of zero");

   a_error_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.encode_error |-> rsp_data.packed_key == KEY_ONES)
      else $error("encode error without all-ones key");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      chain_valid[AXES_BUILT] && !out_adv |=> chain_valid[AXES_BUILT])
      else $error("item left the last slice while output was stalled");

endmodule
`default_nettype wire
